/* rtl/kufef_pkg.sv */
// Shared types and constants of the Kruskal union-find edge filter.
package kufef_pkg;

	localparam int CNT_W     = 9;
	localparam int NODE_W    = 8;
	localparam int WEIGHT_W  = 24;
	localparam int RANK_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	localparam logic FUNC_CLEAR = 1'b0;
	localparam logic FUNC_EDGE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SETS = 2'd1;

	typedef struct packed {
		logic                func;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
	} req_t;

	typedef struct packed {
		logic                accepted;
		logic                finished;
		logic [CNT_W-1:0]    sets_left;
		logic [WEIGHT_W-1:0] bottleneck;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_FIND_A,
		ST_FIND_B,
		ST_BUMP,
		ST_DONE
	} state_t;

endpackage

/* rtl/kruskal_union_find_edge_filter_core.sv */
// Kruskal edge filter: union-find by rank over one parent/rank memory.
// Edge request: accept, then (nodes in range, sets above target) parent walks from node_a and node_b,
// a bump state when a rank rises, then the response load; the parent walks set the rate.
// Clear request: accept, a sweep of all MAX_NODES memory entries, then the response load.
// One request is in flight at a time; the next is taken once the response is loaded.
// Reset (arst_n low, asynchronous) restores the registers and then runs a sweep of all MAX_NODES
// memory entries, during which no request is taken; configuration writes are taken.
module kruskal_union_find_edge_filter_core
	import kufef_pkg::*;
#(
	parameter int MAX_NODES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CMP_W     = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
	localparam int RESET_CNT = (MAX_NODES < 256) ? MAX_NODES : 256;
	localparam logic [CMP_W-1:0] MAXN_C    = CMP_W'(MAX_NODES);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_NODES - 1);

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  parent;
	} entry_t;

	entry_t store_q [MAX_NODES];
	entry_t rd_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0]    node_count_q, target_q, count_q;
	logic [WEIGHT_W-1:0] last_w_q, w_q;
	logic [IDX_W-1:0]    sweep_q, cur_q, b_q, ra_q;
	logic [RANK_W-1:0]   rka_q;
	logic                clr_q, acc_q, rsp_valid_q;
	rsp_t                rsp_q;

	logic [IDX_W-1:0]  rd_addr, wr_addr;
	logic              wr_en;
	entry_t            wr_data;
	logic              load_rsp;

	logic [CMP_W-1:0]  nc_ext, eff_ext;
	logic [CNT_W-1:0]  eff;
	logic              a_ok, b_ok, is_root;

	logic              swap, bump;
	logic [IDX_W-1:0]  link_x, link_y;
	logic [RANK_W-1:0] rank_x, rank_y;

	// The node count in use saturates into 1..MAX_NODES.
	always_comb begin
		nc_ext = CMP_W'(node_count_q);
		if (nc_ext == '0) begin
			eff_ext = CMP_W'(1);
		end else if (nc_ext > MAXN_C) begin
			eff_ext = MAXN_C;
		end else begin
			eff_ext = nc_ext;
		end
		eff  = CNT_W'(eff_ext);
		a_ok = CMP_W'(req.node_a) < eff_ext;
		b_ok = CMP_W'(req.node_b) < eff_ext;
	end

	// Union decision on the two roots; on equal ranks the root of node_b wins.
	always_comb begin
		is_root = (rd_q.parent == cur_q);
		swap    = rka_q > rd_q.rank;
		link_x  = swap ? cur_q : ra_q;
		link_y  = swap ? ra_q : cur_q;
		rank_x  = swap ? rd_q.rank : rka_q;
		rank_y  = swap ? rka_q : rd_q.rank;
		bump    = (rank_x == rank_y) && (rank_y != RANK_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = cur_q;
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = '0;
		req_ready = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '{rank: '0, parent: sweep_q};
				if (sweep_q == LAST_IDX) begin
					state_d = clr_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_addr   = IDX_W'(req.node_a);
				if (req_valid) begin
					if (req.func == FUNC_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (count_q > target_q && a_ok && b_ok) begin
						state_d = ST_FIND_A;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FIND_A: begin
				if (is_root) begin
					rd_addr = b_q;
					state_d = ST_FIND_B;
				end else begin
					rd_addr = rd_q.parent;
				end
			end
			ST_FIND_B: begin
				if (!is_root) begin
					rd_addr = rd_q.parent;
				end else if (ra_q == cur_q) begin
					state_d = ST_DONE;
				end else begin
					wr_en   = 1'b1;
					wr_addr = link_x;
					wr_data = '{rank: rank_x, parent: link_y};
					state_d = bump ? ST_BUMP : ST_DONE;
				end
			end
			ST_BUMP: begin
				wr_en   = 1'b1;
				wr_addr = ra_q;
				wr_data = '{rank: rka_q + RANK_W'(1), parent: ra_q};
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Reads and writes never target the same cycle's read data, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_q <= store_q[rd_addr];
	end

	// Walk and union payload registers.
	always_ff @(posedge clk) begin
		cur_q <= rd_addr;
		if (state_q == ST_IDLE && req_valid) begin
			b_q <= IDX_W'(req.node_b);
			w_q <= req.weight;
		end
		if (state_q == ST_FIND_A && is_root) begin
			ra_q  <= cur_q;
			rka_q <= rd_q.rank;
		end
		// The bump stage reuses ra_q and rka_q for the surviving root.
		if (state_q == ST_FIND_B && is_root) begin
			ra_q  <= link_y;
			rka_q <= rank_y;
		end
		if (load_rsp) begin
			rsp_q.accepted   <= acc_q;
			rsp_q.finished   <= count_q <= target_q;
			rsp_q.sets_left  <= count_q;
			rsp_q.bottleneck <= last_w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(256);
			target_q     <= CNT_W'(1);
			count_q      <= CNT_W'(RESET_CNT);
			last_w_q     <= '0;
			sweep_q      <= '0;
			clr_q        <= 1'b0;
			acc_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_NODE_COUNT:  node_count_q <= cfg_data;
					REG_TARGET_SETS: target_q     <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_SWEEP) begin
				sweep_q <= (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE && req_valid) begin
				acc_q <= 1'b0;
				clr_q <= (req.func == FUNC_CLEAR);
				if (req.func == FUNC_CLEAR) begin
					count_q  <= eff;
					last_w_q <= '0;
				end
			end
			if (state_q == ST_FIND_B && is_root && ra_q != cur_q) begin
				count_q  <= count_q - CNT_W'(1);
				last_w_q <= w_q;
				acc_q    <= 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/kufef_checker.sv */
// Port-level checker for the edge filter core and its bind statement.
module kufef_checker
	import kufef_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one request is in flight, so the block is busy right after taking one.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// A new response is loaded only from the busy side of the sequencer.
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a request in flight");

	// A join leaves at least one component.
	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |-> rsp.sets_left != '0)
		else $error("accepted edge reports no components left");

endmodule

bind kruskal_union_find_edge_filter_core kufef_checker u_kufef_checker (.*);
